// File: rtl/core/lsf_pkg.sv
// ----------------------------------------------------------------------------
// lsf_pkg
// Shared types and constants of the line substring filter: payload structs,
// configuration view, character codes and register indexes.
// ----------------------------------------------------------------------------
package lsf_pkg;

    localparam int REG_BYTES   = 16;  // pattern bytes held in the two registers
    localparam int PAT_LEN_W   = 5;   // width of the pattern length register
    localparam int PAT_IDX_W   = 4;   // index into the held pattern bytes
    localparam int REG_IDX_W   = 2;   // register index taken from the address
    localparam int ADDR_W      = 5;   // byte address, registers at 8*i
    localparam int DATA_W      = 64;

    localparam logic [7:0] CHAR_LF  = 8'h0A;
    localparam logic [7:0] CHAR_CR  = 8'h0D;
    localparam logic [7:0] CHAR_NUL = 8'h00;

    localparam logic [REG_IDX_W-1:0] REG_PAT_FIRST = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_PAT_LAST  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_PAT_LEN   = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_marker;
    } in_item_t;

    typedef struct packed {
        logic        line_matched;
        logic [8:0]  line_length;
        logic [31:0] line_number;
        logic        any_match;
        logic        file_done;
    } out_item_t;

    // Pattern as seen by the line engine: bytes plus effective length.
    typedef struct packed {
        logic [REG_BYTES-1:0][7:0] pat;
        logic [PAT_LEN_W-1:0]      plen;
    } cfg_t;

endpackage

// File: rtl/core/lsf_cfg.sv
// ----------------------------------------------------------------------------
// lsf_cfg
// APB register file for the pattern. Also works out the effective pattern
// length: saturated to the held bytes and the window, cut at a zero byte.
// ----------------------------------------------------------------------------
module lsf_cfg #(
    parameter int MAX_PATTERN = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lsf_pkg::ADDR_W-1:0]    paddr,
    input  logic [lsf_pkg::DATA_W-1:0]    pwdata,
    output logic [lsf_pkg::DATA_W-1:0]    prdata,
    output lsf_pkg::cfg_t                 cfg
);

    localparam int PAT_SLOTS =
        (MAX_PATTERN < lsf_pkg::REG_BYTES) ? MAX_PATTERN : lsf_pkg::REG_BYTES;

    logic [63:0]                    pat_first_reg;
    logic [63:0]                    pat_last_reg;
    logic [lsf_pkg::PAT_LEN_W-1:0]  pat_len_reg;
    logic [lsf_pkg::REG_IDX_W-1:0]  reg_idx;
    logic                           wr_en;
    logic [lsf_pkg::PAT_LEN_W-1:0]  sat_len;
    logic [lsf_pkg::PAT_LEN_W-1:0]  eff_len;

    assign reg_idx = paddr[lsf_pkg::ADDR_W-1:3];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_first_reg <= '0;
            pat_last_reg  <= '0;
            pat_len_reg   <= '0;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                lsf_pkg::REG_PAT_FIRST: pat_first_reg <= pwdata;
                lsf_pkg::REG_PAT_LAST:  pat_last_reg  <= pwdata;
                lsf_pkg::REG_PAT_LEN:   pat_len_reg   <= pwdata[lsf_pkg::PAT_LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            lsf_pkg::REG_PAT_FIRST: prdata = pat_first_reg;
            lsf_pkg::REG_PAT_LAST:  prdata = pat_last_reg;
            lsf_pkg::REG_PAT_LEN:   prdata = 64'(pat_len_reg);
            default:                prdata = '0;
        endcase
    end

    assign cfg.pat = {pat_last_reg, pat_first_reg};

    // Saturate, then cut at the first zero byte of the pattern.
    always_comb
    begin
        sat_len = (pat_len_reg > lsf_pkg::PAT_LEN_W'(PAT_SLOTS)) ?
                  lsf_pkg::PAT_LEN_W'(PAT_SLOTS) : pat_len_reg;
        eff_len = sat_len;
        for (int i = lsf_pkg::REG_BYTES - 1; i >= 0; i--)
        begin
            if ((lsf_pkg::PAT_LEN_W'(i) < sat_len) && (cfg.pat[i] == lsf_pkg::CHAR_NUL))
                eff_len = lsf_pkg::PAT_LEN_W'(i);
        end
    end

    assign cfg.plen = eff_len;

endmodule

// File: rtl/core/lsf_engine.sv
// ----------------------------------------------------------------------------
// lsf_engine
// Line engine: input register, per-byte line state update with window compare,
// and result register. One byte is processed per cycle while no closing byte waits on a pending result.
// ----------------------------------------------------------------------------
module lsf_engine #(
    parameter int MAX_PATTERN   = 16,
    parameter int LINE_CAPACITY = 512
) (
    input  logic               clk,
    input  logic               rst_n,
    input  lsf_pkg::cfg_t      cfg,
    input  logic               in_valid,
    output logic               in_ready,
    input  lsf_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output lsf_pkg::out_item_t out_data
);

    localparam int CW = $clog2(LINE_CAPACITY);
    localparam logic [CW-1:0] STORE_LIMIT = CW'(LINE_CAPACITY - 1);

    // input stage
    logic               in_valid_reg;
    lsf_pkg::in_item_t  in_item_reg;

    // line state
    logic [MAX_PATTERN-1:0][7:0] window_reg;
    logic [MAX_PATTERN-1:0][7:0] window_next;
    logic [CW-1:0]               stored_count_reg, stored_count_next;
    logic [CW-1:0]               visible_count_reg, visible_count_next;
    logic                        zero_seen_reg, zero_seen_next;
    logic                        line_hit_reg, line_hit_next;
    logic [31:0]                 lines_done_reg, lines_done_next;
    logic                        hit_any_reg, hit_any_next;

    // result stage
    logic               out_valid_reg;
    lsf_pkg::out_item_t out_item_reg, out_item_next;

    logic                         closes;
    logic                         advance;
    logic                         matched;
    logic                         window_eq;
    logic [7:0]                   c;
    logic [lsf_pkg::PAT_IDX_W-1:0] pidx;

    assign c       = in_item_reg.data_byte;
    assign closes  = in_item_reg.end_marker || (c == lsf_pkg::CHAR_LF) ||
                     !(stored_count_reg < STORE_LIMIT);
    assign advance = in_valid_reg && (!closes || !out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;
    assign matched  = line_hit_reg || (cfg.plen == '0);

    // Shifted window and compare of its newest characters against the pattern.
    always_comb
    begin
        window_next    = window_reg;
        window_next[0] = c;
        for (int k = 1; k < MAX_PATTERN; k++)
            window_next[k] = window_reg[k-1];
        window_eq = 1'b1;
        pidx      = '0;
        for (int k = 0; k < MAX_PATTERN; k++)
        begin
            if (k < int'(cfg.plen))
            begin
                pidx = lsf_pkg::PAT_IDX_W'(cfg.plen - lsf_pkg::PAT_LEN_W'(1)
                                          - lsf_pkg::PAT_LEN_W'(k));
                if (window_next[k] != cfg.pat[pidx])
                    window_eq = 1'b0;
            end
        end
    end

    always_comb
    begin
        stored_count_next  = stored_count_reg;
        visible_count_next = visible_count_reg;
        zero_seen_next     = zero_seen_reg;
        line_hit_next      = line_hit_reg;
        lines_done_next    = lines_done_reg;
        hit_any_next       = hit_any_reg;

        out_item_next.line_matched = matched;
        out_item_next.line_length  = 9'(visible_count_reg);
        out_item_next.line_number  = lines_done_reg;
        out_item_next.any_match    = hit_any_reg || matched;
        out_item_next.file_done    = in_item_reg.end_marker;

        if (closes)
        begin
            stored_count_next  = '0;
            visible_count_next = '0;
            zero_seen_next     = 1'b0;
            line_hit_next      = 1'b0;
            if (in_item_reg.end_marker)
            begin
                lines_done_next = '0;
                hit_any_next    = 1'b0;
            end
            else
            begin
                lines_done_next = lines_done_reg + 32'd1;
                hit_any_next    = hit_any_reg || matched;
            end
        end
        else if (c != lsf_pkg::CHAR_CR)
        begin
            stored_count_next = stored_count_reg + CW'(1);
            if (c == lsf_pkg::CHAR_NUL)
                zero_seen_next = 1'b1;
            else if (!zero_seen_reg)
            begin
                visible_count_next = visible_count_reg + CW'(1);
                if ((cfg.plen != '0) && (32'(visible_count_next) >= 32'(cfg.plen))
                    && window_eq)
                    line_hit_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg      <= 1'b0;
            stored_count_reg  <= '0;
            visible_count_reg <= '0;
            zero_seen_reg     <= 1'b0;
            line_hit_reg      <= 1'b0;
            lines_done_reg    <= '0;
            hit_any_reg       <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (advance)
            begin
                stored_count_reg  <= stored_count_next;
                visible_count_reg <= visible_count_next;
                zero_seen_reg     <= zero_seen_next;
                line_hit_reg      <= line_hit_next;
                lines_done_reg    <= lines_done_next;
                hit_any_reg       <= hit_any_next;
            end
            if (advance && closes)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_ready)
            in_item_reg <= in_data;
        // advance the window only for visible characters
        if (advance && !closes && (c != lsf_pkg::CHAR_CR) &&
            (c != lsf_pkg::CHAR_NUL) && !zero_seen_reg)
            window_reg <= window_next;
        if (advance && closes)
            out_item_reg <= out_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

endmodule

// File: rtl/core/line_substring_filter_top.sv
// ----------------------------------------------------------------------------
// line_substring_filter_top
// Splits a byte stream into lines and flags each line holding a pattern.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready/in_data) carries one file byte or the
//   end marker per transfer. Output channel (out_valid/out_ready/out_data)
//   carries one result per finished line: match flag, visible length, line
//   number, running match flag and end-of-file flag.
//   The pattern is set over the APB port: pattern bytes 0..7 at 0x00,
//   bytes 8..15 at 0x08, pattern length at 0x10. Write it while idle.
//   Throughput: one byte per cycle, set by the single input register to
//   result register pass (combinational window compare), while no closing
//   byte waits for a pending result. A result is registered: the byte that
//   closes the line passes the input register, then the result register.
//   Stall: while out_ready is low, bytes that do not close a line still
//   flow; a closing byte holds in the input register until the pending
//   result is taken.
//   Reset: clears line state, line counter, match flag and the pattern
//   registers; no clearing pass, ready as soon as reset is released.
//   After the end marker result, line state and counters restart for the
//   next file; the pattern registers keep their values.
// ----------------------------------------------------------------------------
module line_substring_filter_top #(
    parameter int MAX_PATTERN   = 16,
    parameter int LINE_CAPACITY = 512
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [lsf_pkg::ADDR_W-1:0] paddr,
    input  logic [lsf_pkg::DATA_W-1:0] pwdata,
    output logic [lsf_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  lsf_pkg::in_item_t          in_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output lsf_pkg::out_item_t         out_data
);

    lsf_pkg::cfg_t cfg;

    assign pready = 1'b1;

    lsf_cfg #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    lsf_engine #(
        .MAX_PATTERN   (MAX_PATTERN),
        .LINE_CAPACITY (LINE_CAPACITY)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

`ifndef SYNTHESIS
    // A receiver that takes results never blocks the input side.
    a_ready_follows: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("in_ready low while out_ready high");

    // A matched line always sets the running match flag.
    a_any_match: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.line_matched) |-> out_data.any_match)
        else $error("line_matched without any_match");

    // An empty pattern matches every line.
    a_empty_pattern: assert property (@(posedge clk) disable iff (!rst_n)
        (u_engine.advance && u_engine.closes && (cfg.plen == '0)) |=>
        (out_valid && out_data.line_matched))
        else $error("empty pattern line not matched");
`endif

endmodule
